### hw/rtl/bf_pkg.sv
package bf_pkg;

    localparam int ROUND_COUNT  = 16;
    localparam int SBOX_ENTRIES = 256;
    localparam int SBOX_COUNT   = 4;
    localparam int SUBKEY_DEPTH = ROUND_COUNT + 2;
    localparam int WORD_W       = 32;
    localparam int SBOX_ADDR_W  = $clog2(SBOX_ENTRIES);
    localparam int KEY_IDX_W    = $clog2(SUBKEY_DEPTH);
    localparam int ROUND_CNT_W  = $clog2(ROUND_COUNT);

    typedef enum logic [1:0] {
        OP_ENCRYPT    = 2'd0,
        OP_DECRYPT    = 2'd1,
        OP_WRITE_KEY  = 2'd2,
        OP_WRITE_SBOX = 2'd3
    } op_t;

    typedef enum logic {
        ST_IDLE,
        ST_ROUND
    } state_t;

    function automatic logic [WORD_W-1:0] round_f(
        input logic [WORD_W-1:0] s1,
        input logic [WORD_W-1:0] s2,
        input logic [WORD_W-1:0] s3,
        input logic [WORD_W-1:0] s4
    );
        return ((s1 + s2) ^ s3) + s4;
    endfunction

endpackage

### hw/rtl/bf_ram.sv
module bf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### hw/rtl/blowfish_block_cipher_unit.sv
// channel   signals                                        direction
// input     in_valid, in_ready, opcode, table_index,       into block
//           left_half, right_half, last_in
// output    out_valid, out_ready, first_word_out,          out of block
//           second_word_out, last_out
//
// encrypt or decrypt: the accept cycle, then one round per cycle
// through the shared round unit, which reads all four s-box rams each cycle
// table writes give no result
// in_ready is high whenever no block is in its rounds
// a finished block waits in its last round while the output register is full
// rst_n clears control only; subkeys and s-boxes keep their contents
module blowfish_block_cipher_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  opcode,
    input  logic [9:0]  table_index,
    input  logic [31:0] left_half,
    input  logic [31:0] right_half,
    input  logic        last_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] first_word_out,
    output logic [31:0] second_word_out,
    output logic        last_out
);

    localparam int W  = bf_pkg::WORD_W;
    localparam int KW = bf_pkg::KEY_IDX_W;
    localparam int CW = bf_pkg::ROUND_CNT_W;
    localparam int AW = bf_pkg::SBOX_ADDR_W;

    bf_pkg::state_t state_reg, state_next;
    bf_pkg::op_t    op_in;

    logic [CW-1:0] cnt_reg, cnt_next;
    logic          dec_reg, dec_next;
    logic          last_reg, last_next;
    logic [W-1:0]  a_reg, a_next;
    logic [W-1:0]  b_reg, b_next;
    logic          out_valid_reg, out_valid_next;
    logic [W-1:0]  first_reg, first_next;
    logic [W-1:0]  second_reg, second_next;
    logic          last_out_reg, last_out_next;

    logic [W-1:0]  subkey_reg [bf_pkg::SUBKEY_DEPTH];

    logic          accept;
    logic          cipher_req;
    logic          round_last;
    logic          finish;
    logic          dec_sel;
    logic [KW-1:0] key_pos;
    logic [KW-1:0] key_idx;
    logic [W-1:0]  key_word;
    logic [W-1:0]  key_end;
    logic [W-1:0]  f_val;
    logic [W-1:0]  b_mixed;
    logic [W-1:0]  sbox_rdata [bf_pkg::SBOX_COUNT];

    assign op_in      = bf_pkg::op_t'(opcode);
    assign accept     = in_valid && in_ready;
    assign cipher_req = (op_in == bf_pkg::OP_ENCRYPT) || (op_in == bf_pkg::OP_DECRYPT);
    assign round_last = (state_reg == bf_pkg::ST_ROUND) && (cnt_reg == CW'(bf_pkg::ROUND_COUNT - 1));
    assign finish     = round_last && (!out_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bf_pkg::ST_IDLE:
            begin
                if (accept && cipher_req)
                begin
                    state_next = bf_pkg::ST_ROUND;
                end
            end
            bf_pkg::ST_ROUND:
            begin
                if (finish)
                begin
                    state_next = bf_pkg::ST_IDLE;
                end
            end
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        in_ready = 1'b0;
        dec_sel  = dec_reg;
        key_pos  = KW'(cnt_reg) + KW'(1);
        unique case (state_reg)
            bf_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                dec_sel  = (op_in == bf_pkg::OP_DECRYPT);
                key_pos  = '0;
            end
            bf_pkg::ST_ROUND:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

    // subkey order reverses for decrypt
    assign key_idx  = dec_sel ? (KW'(bf_pkg::SUBKEY_DEPTH - 1) - key_pos) : key_pos;
    assign key_word = subkey_reg[key_idx];
    assign key_end  = dec_reg ? subkey_reg[0] : subkey_reg[bf_pkg::SUBKEY_DEPTH - 1];

    assign f_val   = bf_pkg::round_f(sbox_rdata[0], sbox_rdata[1], sbox_rdata[2], sbox_rdata[3]);
    assign b_mixed = b_reg ^ f_val;

    // round datapath
    always_comb
    begin
        cnt_next       = cnt_reg;
        dec_next       = dec_reg;
        last_next      = last_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        out_valid_next = out_valid_reg;
        first_next     = first_reg;
        second_next    = second_reg;
        last_out_next  = last_out_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            bf_pkg::ST_IDLE:
            begin
                if (accept && cipher_req)
                begin
                    cnt_next  = '0;
                    dec_next  = dec_sel;
                    last_next = last_in;
                    a_next    = left_half ^ key_word;
                    b_next    = right_half;
                end
            end
            bf_pkg::ST_ROUND:
            begin
                if (finish)
                begin
                    out_valid_next = 1'b1;
                    first_next     = a_reg ^ key_end;
                    second_next    = b_mixed ^ key_word;
                    last_out_next  = last_reg;
                end
                else if (!round_last)
                begin
                    cnt_next = cnt_reg + CW'(1);
                    a_next   = b_mixed ^ key_word;
                    b_next   = a_reg;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg      <= dec_next;
        last_reg     <= last_next;
        a_reg        <= a_next;
        b_reg        <= b_next;
        first_reg    <= first_next;
        second_reg   <= second_next;
        last_out_reg <= last_out_next;
        if (accept && (op_in == bf_pkg::OP_WRITE_KEY)
            && (table_index < 10'(bf_pkg::SUBKEY_DEPTH)))
        begin
            subkey_reg[table_index[KW-1:0]] <= left_half;
        end
    end

    // one ram per s-box, addressed by the bytes of the next active half
    for (genvar g = 0; g < bf_pkg::SBOX_COUNT; g++)
    begin : g_sbox
        logic          sbox_we;
        logic [AW-1:0] sbox_raddr;

        assign sbox_we    = accept && (op_in == bf_pkg::OP_WRITE_SBOX)
                            && (table_index[9:AW] == 2'(g));
        assign sbox_raddr = a_next[W-1-g*AW -: AW];

        bf_ram #(
            .WIDTH (W),
            .DEPTH (bf_pkg::SBOX_ENTRIES)
        ) u_sbox_ram (
            .clk   (clk),
            .we    (sbox_we),
            .waddr (table_index[AW-1:0]),
            .wdata (left_half),
            .raddr (sbox_raddr),
            .rdata (sbox_rdata[g])
        );
    end

    assign out_valid       = out_valid_reg;
    assign first_word_out  = first_reg;
    assign second_word_out = second_reg;
    assign last_out        = last_out_reg;

    a_cipher_start: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && cipher_req) |=> (state_reg == bf_pkg::ST_ROUND) && (cnt_reg == '0))
        else $error("cipher request did not start rounds at zero");

    a_write_stays_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && !cipher_req) |=> (state_reg == bf_pkg::ST_IDLE))
        else $error("table write left idle");

    a_round_advance: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == bf_pkg::ST_ROUND) && !round_last)
        |=> (cnt_reg == $past(cnt_reg) + CW'(1)) && (state_reg == bf_pkg::ST_ROUND))
        else $error("round counter did not advance");

    a_result_from_last_round: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(round_last))
        else $error("result raised outside the last round");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_ready) |=> out_valid_reg && $stable(first_reg)
        && $stable(second_reg))
        else $error("pending result overwritten");

endmodule
